// ----- sv/kwm_pkg.sv -----
// package for the k-way merge min-select block
// field widths, payload structs, cell control struct and controller states
// no dependencies
package kwm_pkg;

  localparam int KEY_W = 31;
  localparam int PAY_W = 32;
  localparam int LANE_W = 4;
  localparam int CFG_W = 5;
  localparam int MAX_PARTITIONS_DEF = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);
  localparam logic [KEY_W-1:0] KEY_EXHAUSTED = {KEY_W{1'b1}};

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [KEY_W-1:0]  rec_key;
    logic [PAY_W-1:0]  rec_payload;
    logic              lane_end;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0]  out_key;
    logic [PAY_W-1:0]  out_payload;
    logic [LANE_W-1:0] source_lane;
  } out_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } best_t;

  typedef struct packed {
    logic clr;
    logic we;
    logic live;
    logic act;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SWEEP,
    ST_EMIT,
    ST_DONE
  } state_e;

endpackage

// ----- sv/kwm_cell.sv -----
// one merge cell: holds the head record of one lane and compares it
// against the running minimum handed on by its left neighbor
// depends on kwm_pkg
module kwm_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kwm_pkg::cell_ctl_t            ctl_i,
  input  logic [kwm_pkg::KEY_W-1:0]     wr_key_i,
  input  logic [kwm_pkg::PAY_W-1:0]     wr_payload_i,
  input  logic                          tok_i,
  input  kwm_pkg::best_t                best_i,
  input  logic [IDX_W-1:0]              lane_i,
  output logic                          tok_o,
  output kwm_pkg::best_t                best_o,
  output logic [IDX_W-1:0]              lane_o
);
  import kwm_pkg::*;

  logic             live_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;
  logic             tok_q;
  logic             found_q;
  logic [KEY_W-1:0] bkey_q;
  logic [PAY_W-1:0] bpay_q;
  logic [IDX_W-1:0] lane_q;
  logic             mine;

  assign mine = ctl_i.act && live_q && (!best_i.found || (key_q < best_i.key));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q  <= 1'b0;
      tok_q   <= 1'b0;
      found_q <= 1'b0;
    end else if (ctl_i.clr) begin
      live_q  <= 1'b0;
      tok_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        live_q <= ctl_i.live;
      end
      tok_q   <= tok_i;
      found_q <= mine || best_i.found;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we && ctl_i.live) begin
      key_q <= wr_key_i;
      pay_q <= wr_payload_i;
    end
    if (mine) begin
      bkey_q <= key_q;
      bpay_q <= pay_q;
      lane_q <= IDX_W'(IDX);
    end else begin
      bkey_q <= best_i.key;
      bpay_q <= best_i.payload;
      lane_q <= lane_i;
    end
  end

  assign tok_o  = tok_q;
  assign best_o = '{found: found_q, key: bkey_q, payload: bpay_q};
  assign lane_o = lane_q;

endmodule

// ----- sv/k_way_merge_min_select.sv -----
// k-way merge top level: lane controller and a chain of MAX_PARTITIONS cells
// a load that fills the last lane in use starts a sweep; the minimum token walks
// the chain one cell per cycle and the winner is registered, then emitted; input stalls
// until the emit is taken, and fill-phase items before the last lane need no sweep
// reset and a configuration write clear all heads, the fill count and the waiting lane
// depends on kwm_pkg and kwm_cell
module k_way_merge_min_select #(
  parameter int MAX_PARTITIONS = kwm_pkg::MAX_PARTITIONS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  kwm_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output kwm_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [kwm_pkg::CFG_W-1:0] cfg_data_i
);
  import kwm_pkg::*;

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

  state_e           state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  logic [CNT_W-1:0] fill_q, fill_d, fill_nxt, p_eff;
  logic [IDX_W-1:0] wait_q, wait_d, slot;
  logic             start_q;
  logic             res_found_q;
  logic [KEY_W-1:0] res_key_q;
  logic [PAY_W-1:0] res_pay_q;
  logic [IDX_W-1:0] res_lane_q;
  logic             out_valid_q;
  out_t             out_q;
  logic [31:0]      lane_ext;

  logic cfg_wr, in_acc, load_acc, in_fill, sweep_go, live_in, tok_last, out_free, emit;

  logic [MAX_PARTITIONS:0] tok_w;
  best_t                   best_w [MAX_PARTITIONS+1];
  logic [IDX_W-1:0]        lane_w [MAX_PARTITIONS+1];
  cell_ctl_t               ctl_w  [MAX_PARTITIONS];

  always_comb begin
    priority if (cfg_q == '0) begin
      p_eff = CNT_W'(1);
    end else if (32'(cfg_q) > MAX_PARTITIONS) begin
      p_eff = CNT_W'(MAX_PARTITIONS);
    end else begin
      p_eff = CNT_W'(cfg_q);
    end
  end

  assign cfg_wr   = cfg_valid_i && cfg_ready_o;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign load_acc = in_acc && (state_q == ST_LOAD);
  assign in_fill  = fill_q < p_eff;
  assign fill_nxt = fill_q + CNT_W'(1);
  assign slot     = in_fill ? fill_q[IDX_W-1:0] : wait_q;
  assign sweep_go = load_acc && (!in_fill || (fill_nxt >= p_eff));
  assign live_in  = !(in_data_i.lane_end || (in_data_i.rec_key == KEY_EXHAUSTED));
  assign tok_last = tok_w[MAX_PARTITIONS];
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = (state_q == ST_EMIT) && res_found_q && out_free;
  assign lane_ext = 32'(res_lane_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (sweep_go) state_d = ST_SWEEP;
      ST_SWEEP: if (tok_last) state_d = ST_EMIT;
      ST_EMIT: begin
        if (!res_found_q) begin
          state_d = ST_DONE;
        end else if (out_free) begin
          state_d = ST_LOAD;
        end
      end
      ST_DONE:  state_d = ST_DONE;
      default:  state_d = ST_LOAD;
    endcase
    if (cfg_wr) state_d = ST_LOAD;
  end

  // outputs and counters
  always_comb begin
    in_stall_o  = !((state_q == ST_LOAD) || (state_q == ST_DONE));
    cfg_ready_o = 1'b1;
    out_valid_o = out_valid_q;
    out_data_o  = out_q;
    fill_d      = fill_q;
    wait_d      = wait_q;
    if (load_acc && in_fill) fill_d = fill_nxt;
    if (emit) wait_d = res_lane_q;
    if (cfg_wr) begin
      fill_d = '0;
      wait_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cfg_q       <= CFG_RESET;
      fill_q      <= '0;
      wait_q      <= '0;
      start_q     <= 1'b0;
      res_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      wait_q  <= wait_d;
      start_q <= sweep_go && !cfg_wr;
      if (cfg_wr) begin
        cfg_q       <= cfg_data_i;
        res_found_q <= 1'b0;
        out_valid_q <= 1'b0;
      end else begin
        if (tok_last && (state_q == ST_SWEEP)) res_found_q <= best_w[MAX_PARTITIONS].found;
        if (emit) begin
          out_valid_q <= 1'b1;
        end else if (!out_stall_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_last && (state_q == ST_SWEEP)) begin
      res_key_q  <= best_w[MAX_PARTITIONS].key;
      res_pay_q  <= best_w[MAX_PARTITIONS].payload;
      res_lane_q <= lane_w[MAX_PARTITIONS];
    end
    if (emit) begin
      out_q <= '{out_key: res_key_q, out_payload: res_pay_q, source_lane: lane_ext[LANE_W-1:0]};
    end
  end

  // cell chain
  assign tok_w[0]  = start_q;
  assign best_w[0] = '0;
  assign lane_w[0] = '0;

  for (genvar g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
    assign ctl_w[g] = '{
      clr:  cfg_wr,
      we:   load_acc && (slot == IDX_W'(g)),
      live: live_in,
      act:  CNT_W'(g) < p_eff
    };

    kwm_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_w[g]),
      .wr_key_i     (in_data_i.rec_key),
      .wr_payload_i (in_data_i.rec_payload),
      .tok_i        (tok_w[g]),
      .best_i       (best_w[g]),
      .lane_i       (lane_w[g]),
      .tok_o        (tok_w[g+1]),
      .best_o       (best_w[g+1]),
      .lane_o       (lane_w[g+1])
    );
  end

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_w))
    else $error("more than one minimum token in the chain");

  a_token_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_last |-> (state_q == ST_SWEEP))
    else $error("token left the chain outside a sweep");

  a_no_sentinel_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.out_key != KEY_EXHAUSTED))
    else $error("exhausted key emitted");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= p_eff)
    else $error("fill count beyond lanes in use");

  a_sweep_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sweep_go && !cfg_wr) |=> (state_q == ST_SWEEP) && start_q)
    else $error("sweep did not start after last load");

endmodule
